[sv/aacb_pkg.sv]
// Shared constants, codes and types of the coverage blend pixel pipeline.
package aacb_pkg;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_THRESHOLD = 1'b1;

    localparam int THR_W = 17;
    localparam logic [THR_W-1:0] OPAQUE_RESET = 17'd64770;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int WORD_W  = 18;
    localparam int DIST_W  = 8;
    localparam int LIDX_W  = WORD_W - CHAN_W;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam int FILT_W = 11;
    localparam int PROD_W = 18;
    localparam int FRAC_W = 16;
    localparam int MIX_W  = PROD_W + CHAN_W + 1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } aacb_qstat_t;

    function automatic int entry_bits(input int addr_w, input int coord_w);
        return 2 + 5 * addr_w + 3 * CHAN_W + 2 * COLOR_W + 2 * coord_w;
    endfunction

endpackage

[sv/aacb_front.sv]
// Front end: input handshake, item decode, index clamping and table address forming.
module aacb_front
    import aacb_pkg::*;
#(
    parameter int TABLE_SIDE = 32,
    parameter int COORD_BITS = 11,
    localparam int IDX_W     = $clog2(TABLE_SIDE),
    localparam int ADDR_W    = $clog2(TABLE_SIDE * TABLE_SIDE),
    localparam int ENTRY_W   = entry_bits(ADDR_W, COORD_BITS)
)
(
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [WORD_W-1:0]        table_word,
    input  logic signed [DIST_W-1:0] near_a,
    input  logic signed [DIST_W-1:0] far_a,
    input  logic signed [DIST_W-1:0] near_b,
    input  logic signed [DIST_W-1:0] far_b,
    input  logic [COLOR_W-1:0]       source_color,
    input  logic [CHAN_W-1:0]        weight,
    input  logic [COLOR_W-1:0]       dest_pixel,
    input  logic [CHAN_W-1:0]        dest_alpha,
    input  logic [COORD_BITS-1:0]    pixel_x,
    input  logic [COORD_BITS-1:0]    pixel_y,
    input  aacb_qstat_t              qstat,
    output logic                     push,
    output logic [ENTRY_W-1:0]       entry
);

    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [DIST_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(DIST_W'(TABLE_SIDE - 1)))
        begin
            r = IDX_W'(TABLE_SIDE - 1);
        end
        else
        begin
            r = v[IDX_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] table_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(TABLE_SIDE) + ADDR_W'(col);
    endfunction

    logic [IDX_W-1:0]  na, fa, nb, fb;
    logic [LIDX_W-1:0] load_idx;
    logic              load_ok;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] a_nn, a_fn, a_nf, a_ff;

    assign na = clamp_idx(near_a);
    assign fa = clamp_idx(far_a);
    assign nb = clamp_idx(near_b);
    assign fb = clamp_idx(far_b);

    assign a_nn = table_addr(na, nb);
    assign a_fn = table_addr(fa, nb);
    assign a_nf = table_addr(na, fb);
    assign a_ff = table_addr(fa, fb);

    assign load_idx  = table_word[WORD_W-1:CHAN_W];
    assign load_ok   = 32'(load_idx) < 32'(TABLE_SIDE * TABLE_SIDE);
    assign load_addr = ADDR_W'(load_idx);

    assign in_ready = !qstat.full;
    assign push     = in_valid && !qstat.full;

    assign entry = {action, load_ok, load_addr, table_word[CHAN_W-1:0],
                    a_nn, a_fn, a_nf, a_ff,
                    source_color, weight, dest_pixel, dest_alpha,
                    pixel_x, pixel_y};

endmodule

[sv/aacb_fifo.sv]
// Short word queue between the front end and the blend pipeline.
module aacb_fifo
    import aacb_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output aacb_qstat_t      qstat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data     = slot_reg[rd_ptr_reg];
    assign qstat.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count lost a push");
`endif

endmodule

[sv/aacb_back.sv]
// Back end: coverage table copies, filter, weight product and channel blend pipeline.
module aacb_back
    import aacb_pkg::*;
#(
    parameter int TABLE_SIDE = 32,
    parameter int COORD_BITS = 11,
    localparam int ADDR_W    = $clog2(TABLE_SIDE * TABLE_SIDE),
    localparam int DEPTH     = TABLE_SIDE * TABLE_SIDE,
    localparam int ENTRY_W   = entry_bits(ADDR_W, COORD_BITS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [THR_W-1:0]      cfg_data,
    input  aacb_qstat_t           qstat,
    input  logic [ENTRY_W-1:0]    rd_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    new_pixel,
    output logic [CHAN_W-1:0]     new_alpha,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y
);

    typedef struct packed {
        logic                  action;
        logic                  load_ok;
        logic [ADDR_W-1:0]     load_addr;
        logic [CHAN_W-1:0]     load_byte;
        logic [ADDR_W-1:0]     a_nn;
        logic [ADDR_W-1:0]     a_fn;
        logic [ADDR_W-1:0]     a_nf;
        logic [ADDR_W-1:0]     a_ff;
        logic [COLOR_W-1:0]    src;
        logic [CHAN_W-1:0]     weight;
        logic [COLOR_W-1:0]    dest;
        logic [CHAN_W-1:0]     alpha;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } entry_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    src;
        logic [COLOR_W-1:0]    dest;
        logic [CHAN_W-1:0]     alpha;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pix_t;

    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] d,
                                                     input logic [CHAN_W-1:0] c,
                                                     input logic signed [PROD_W-1:0] f);
        logic signed [CHAN_W:0]  diff;
        logic signed [MIX_W-1:0] diff_ext;
        logic signed [MIX_W-1:0] f_ext;
        logic signed [MIX_W-1:0] mix;
        diff     = $signed({1'b0, c}) - $signed({1'b0, d});
        diff_ext = MIX_W'(diff);
        f_ext    = MIX_W'(f);
        mix      = diff_ext * f_ext;
        return d + mix[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

    entry_t e;
    logic   advance;

    logic               alpha_en_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [CHAN_W-1:0] cov_a_mem [DEPTH];
    logic [CHAN_W-1:0] cov_b_mem [DEPTH];

    logic                     s1_valid_reg;
    logic [CHAN_W-1:0]        rd_nn_reg, rd_fn_reg, rd_nf_reg, rd_ff_reg;
    logic [CHAN_W-1:0]        s1_weight_reg;
    pix_t                     s1_pix_reg;

    logic                     s2_valid_reg;
    logic signed [FILT_W-1:0] s2_filter_reg, filter_next;
    logic [CHAN_W-1:0]        s2_weight_reg;
    pix_t                     s2_pix_reg;

    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_prod_reg, prod_next;
    logic signed [PROD_W-1:0] filt_ext, wgt_ext;
    pix_t                     s3_pix_reg;

    logic                     opaque;
    logic [CHAN_W-1:0]        red_mix, green_mix, blue_mix, alpha_mix;
    logic [COLOR_W-1:0]       pixel_next;
    logic [CHAN_W-1:0]        alpha_next;

    logic                     out_valid_reg;
    logic [COLOR_W-1:0]       new_pixel_reg;
    logic [CHAN_W-1:0]        new_alpha_reg;
    logic [COORD_BITS-1:0]    out_x_reg, out_y_reg;

    assign e       = rd_entry;
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_en_reg <= 1'b0;
            thr_reg      <= OPAQUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA_ENABLE:     alpha_en_reg <= cfg_data[0];
                REG_OPAQUE_THRESHOLD: thr_reg      <= cfg_data;
                default:              ;
            endcase
        end
    end

    // two copies of the table, each read at two addresses per word
    always_ff @(posedge clk)
    begin
        if (pop && e.action == ACT_LOAD && e.load_ok)
        begin
            cov_a_mem[e.load_addr] <= e.load_byte;
            cov_b_mem[e.load_addr] <= e.load_byte;
        end
        if (advance)
        begin
            rd_nn_reg <= cov_a_mem[e.a_nn];
            rd_fn_reg <= cov_a_mem[e.a_fn];
            rd_nf_reg <= cov_b_mem[e.a_nf];
            rd_ff_reg <= cov_b_mem[e.a_ff];
        end
    end

    assign filter_next = FILT_W'(rd_nn_reg) - FILT_W'(rd_fn_reg) - FILT_W'(rd_nf_reg)
                       + FILT_W'(rd_ff_reg) + FILT_W'(1);

    assign filt_ext  = PROD_W'(s2_filter_reg);
    assign wgt_ext   = PROD_W'(s2_weight_reg);
    assign prod_next = filt_ext * wgt_ext;

    assign opaque = !s3_prod_reg[PROD_W-1] && (s3_prod_reg[THR_W-1:0] >= thr_reg);

    assign red_mix   = blend_chan(s3_pix_reg.dest[3*CHAN_W-1:2*CHAN_W],
                                  s3_pix_reg.src[3*CHAN_W-1:2*CHAN_W], s3_prod_reg);
    assign green_mix = blend_chan(s3_pix_reg.dest[2*CHAN_W-1:CHAN_W],
                                  s3_pix_reg.src[2*CHAN_W-1:CHAN_W], s3_prod_reg);
    assign blue_mix  = blend_chan(s3_pix_reg.dest[CHAN_W-1:0],
                                  s3_pix_reg.src[CHAN_W-1:0], s3_prod_reg);
    assign alpha_mix = blend_chan(s3_pix_reg.alpha, CHAN_MAX, s3_prod_reg);

    assign pixel_next = opaque ? s3_pix_reg.src : {red_mix, green_mix, blue_mix};
    assign alpha_next = alpha_en_reg ? alpha_mix : s3_pix_reg.alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop && e.action == ACT_BLEND;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_weight_reg  <= e.weight;
            s1_pix_reg     <= '{src: e.src, dest: e.dest, alpha: e.alpha, x: e.x, y: e.y};
            s2_filter_reg  <= filter_next;
            s2_weight_reg  <= s1_weight_reg;
            s2_pix_reg     <= s1_pix_reg;
            s3_prod_reg    <= prod_next;
            s3_pix_reg     <= s2_pix_reg;
            new_pixel_reg  <= pixel_next;
            new_alpha_reg  <= alpha_next;
            out_x_reg      <= s3_pix_reg.x;
            out_y_reg      <= s3_pix_reg.y;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pixel = new_pixel_reg;
    assign new_alpha = new_alpha_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s3_valid_reg && opaque |=> new_pixel_reg == $past(s3_pix_reg.src))
        else $error("opaque word did not take the source color");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s3_valid_reg && !alpha_en_reg |=> new_alpha_reg == $past(s3_pix_reg.alpha))
        else $error("alpha changed while alpha blending is off");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(new_pixel_reg)
            && $stable(new_alpha_reg))
        else $error("result word changed while stalled");
`endif

endmodule

[sv/aa_coverage_blend_rgb.sv]
// Top level of the antialiased line pixel blender.
// Takes one word per cycle while its queue has room and delivers one blended pixel per
// blend word; load words write the coverage table and give no result. Accepted words
// pass through a four-word queue into a pipeline of table read, filter sum, weight
// product and channel blend; the table is held in two copies, each read at two
// addresses per cycle, so the four lookups of a word are made together. The table must
// be loaded before a blend word reads an entry.
module aa_coverage_blend_rgb
    import aacb_pkg::*;
#(
    parameter int TABLE_SIDE = 32,
    parameter int COORD_BITS = 11
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [THR_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [WORD_W-1:0]        table_word,
    input  logic signed [DIST_W-1:0] near_a,
    input  logic signed [DIST_W-1:0] far_a,
    input  logic signed [DIST_W-1:0] near_b,
    input  logic signed [DIST_W-1:0] far_b,
    input  logic [COLOR_W-1:0]       source_color,
    input  logic [CHAN_W-1:0]        weight,
    input  logic [COLOR_W-1:0]       dest_pixel,
    input  logic [CHAN_W-1:0]        dest_alpha,
    input  logic [COORD_BITS-1:0]    pixel_x,
    input  logic [COORD_BITS-1:0]    pixel_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COLOR_W-1:0]       new_pixel,
    output logic [CHAN_W-1:0]        new_alpha,
    output logic [COORD_BITS-1:0]    out_x,
    output logic [COORD_BITS-1:0]    out_y
);

    localparam int ADDR_W  = $clog2(TABLE_SIDE * TABLE_SIDE);
    localparam int ENTRY_W = entry_bits(ADDR_W, COORD_BITS);

    aacb_qstat_t        qstat;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    aacb_front #(
        .TABLE_SIDE (TABLE_SIDE),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .table_word   (table_word),
        .near_a       (near_a),
        .far_a        (far_a),
        .near_b       (near_b),
        .far_b        (far_b),
        .source_color (source_color),
        .weight       (weight),
        .dest_pixel   (dest_pixel),
        .dest_alpha   (dest_alpha),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .qstat        (qstat),
        .push         (push),
        .entry        (wr_entry)
    );

    aacb_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .qstat   (qstat)
    );

    aacb_back #(
        .TABLE_SIDE (TABLE_SIDE),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .rd_entry  (rd_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .new_pixel (new_pixel),
        .new_alpha (new_alpha),
        .out_x     (out_x),
        .out_y     (out_y)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the coverage table pixel blender, with its own blend predictor.
module testbench
    import aacb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE         = 32;
    localparam int COORD        = 11;
    localparam int LIVE_N       = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int FLUSH_CYCLES = 16;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    typedef struct {
        logic                     action;
        logic [WORD_W-1:0]        table_word;
        logic signed [DIST_W-1:0] near_a;
        logic signed [DIST_W-1:0] far_a;
        logic signed [DIST_W-1:0] near_b;
        logic signed [DIST_W-1:0] far_b;
        logic [COLOR_W-1:0]       source_color;
        logic [CHAN_W-1:0]        weight;
        logic [COLOR_W-1:0]       dest_pixel;
        logic [CHAN_W-1:0]        dest_alpha;
        logic [COORD-1:0]         pixel_x;
        logic [COORD-1:0]         pixel_y;
    } blend_word_t;

    typedef struct {
        logic [COLOR_W-1:0] pixel;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD-1:0]   x;
        logic [COORD-1:0]   y;
    } pixel_result_t;

    class blend_ledger;
        logic [CHAN_W-1:0] coverage [SIDE*SIDE];
        logic              alpha_on;
        logic [THR_W-1:0]  threshold;
        pixel_result_t     pending_pixels [$];
        int                errors;

        function new();
            foreach (coverage[i]) coverage[i] = '0;
            alpha_on  = 1'b0;
            threshold = OPAQUE_RESET;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
            if (idx == REG_ALPHA_ENABLE)
                alpha_on = data[0];
            else if (idx == REG_OPAQUE_THRESHOLD)
                threshold = data;
        endfunction

        function int clamp_dist(logic signed [DIST_W-1:0] v);
            if (v < 0)
                return 0;
            if (v > SIDE - 1)
                return SIDE - 1;
            return int'(v);
        endfunction

        function logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] d, logic [CHAN_W-1:0] c,
                                             int filt);
            longint prod;
            longint sum;
            prod = (longint'(c) - longint'(d)) * longint'(filt);
            sum  = longint'(d) + (prod >>> FRAC_W);
            return sum[CHAN_W-1:0];
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        function void take_word(blend_word_t w);
            int            idx;
            int            na;
            int            fa;
            int            nb;
            int            fb;
            int            filt;
            pixel_result_t res;
            if (w.action == ACT_LOAD)
            begin
                idx = int'(w.table_word >> CHAN_W);
                if (idx < SIDE * SIDE)
                    coverage[idx] = w.table_word[CHAN_W-1:0];
                return;
            end
            na = clamp_dist(w.near_a);
            fa = clamp_dist(w.far_a);
            nb = clamp_dist(w.near_b);
            fb = clamp_dist(w.far_b);
            filt = int'(coverage[na*SIDE+nb]) - int'(coverage[fa*SIDE+nb])
                 - int'(coverage[na*SIDE+fb]) + int'(coverage[fa*SIDE+fb]) + 1;
            filt = filt * int'(w.weight);
            if (filt < int'(threshold))
            begin
                res.pixel[23:16] = mix_chan(w.dest_pixel[23:16], w.source_color[23:16], filt);
                res.pixel[15:8]  = mix_chan(w.dest_pixel[15:8], w.source_color[15:8], filt);
                res.pixel[7:0]   = mix_chan(w.dest_pixel[7:0], w.source_color[7:0], filt);
            end
            else
            begin
                res.pixel = w.source_color;
            end
            res.alpha = alpha_on ? mix_chan(w.dest_alpha, CHAN_MAX, filt) : w.dest_alpha;
            res.x = w.pixel_x;
            res.y = w.pixel_y;
            pending_pixels.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_pixel(logic [COLOR_W-1:0] pixel, logic [CHAN_W-1:0] alpha,
                                  logic [COORD-1:0] x, logic [COORD-1:0] y);
            pixel_result_t want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel with nothing pending, expected none, actual %0h",
                         $time, pixel);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("new_pixel", want.pixel, pixel);
            compare_field("new_alpha", want.alpha, alpha);
            compare_field("out_x", want.x, x);
            compare_field("out_y", want.y, y);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_ALPHA_ENABLE;
    logic [THR_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     action = ACT_LOAD;
    logic [WORD_W-1:0]        table_word = '0;
    logic signed [DIST_W-1:0] near_a = '0;
    logic signed [DIST_W-1:0] far_a = '0;
    logic signed [DIST_W-1:0] near_b = '0;
    logic signed [DIST_W-1:0] far_b = '0;
    logic [COLOR_W-1:0]       source_color = '0;
    logic [CHAN_W-1:0]        weight = '0;
    logic [COLOR_W-1:0]       dest_pixel = '0;
    logic [CHAN_W-1:0]        dest_alpha = '0;
    logic [COORD-1:0]         pixel_x = '0;
    logic [COORD-1:0]         pixel_y = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [COLOR_W-1:0]       new_pixel;
    logic [CHAN_W-1:0]        new_alpha;
    logic [COORD-1:0]         out_x;
    logic [COORD-1:0]         out_y;

    blend_ledger sb = new();
    blend_word_t seen_word;

    int          live_idx [LIVE_N] = '{0, 1, 5, 7, 9, 16, SIDE - 2, SIDE - 1};

    int          stall_mode = 0;
    int          stall_count = 0;
    logic [15:0] stall_pat = 16'h0001;

    aa_coverage_blend_rgb #(
        .TABLE_SIDE(SIDE),
        .COORD_BITS(COORD)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .table_word(table_word),
        .near_a(near_a),
        .far_a(far_a),
        .near_b(near_b),
        .far_b(far_b),
        .source_color(source_color),
        .weight(weight),
        .dest_pixel(dest_pixel),
        .dest_alpha(dest_alpha),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .new_pixel(new_pixel),
        .new_alpha(new_alpha),
        .out_x(out_x),
        .out_y(out_y)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            seen_word.action       = action;
            seen_word.table_word   = table_word;
            seen_word.near_a       = near_a;
            seen_word.far_a        = far_a;
            seen_word.near_b       = near_b;
            seen_word.far_b        = far_b;
            seen_word.source_color = source_color;
            seen_word.weight       = weight;
            seen_word.dest_pixel   = dest_pixel;
            seen_word.dest_alpha   = dest_alpha;
            seen_word.pixel_x      = pixel_x;
            seen_word.pixel_y      = pixel_y;
            sb.take_word(seen_word);
        end
        if (rst_n && out_valid && out_ready)
            sb.match_pixel(new_pixel, new_alpha, out_x, out_y);
    end

    // stall the output side in randomly chosen modes, each held for a random run
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_pat   <= 16'($urandom) | 16'h0001;
            stall_count <= $urandom_range(16, 96);
        end
        else
        begin
            stall_count <= stall_count - 1;
            stall_pat   <= {stall_pat[0], stall_pat[15:1]};
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= stall_pat[0];
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_word(blend_word_t w);
        in_valid     <= 1'b1;
        action       <= w.action;
        table_word   <= w.table_word;
        near_a       <= w.near_a;
        far_a        <= w.far_a;
        near_b       <= w.near_b;
        far_b        <= w.far_b;
        source_color <= w.source_color;
        weight       <= w.weight;
        dest_pixel   <= w.dest_pixel;
        dest_alpha   <= w.dest_alpha;
        pixel_x      <= w.pixel_x;
        pixel_y      <= w.pixel_y;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_entry(int row, int col, logic [CHAN_W-1:0] cov);
        blend_word_t w;
        w = '{default: '0};
        w.action     = ACT_LOAD;
        w.table_word = WORD_W'((row * SIDE + col) * 256) | WORD_W'(cov);
        send_word(w);
    endtask

    task automatic blend_at(logic signed [DIST_W-1:0] na, logic signed [DIST_W-1:0] fa,
                            logic signed [DIST_W-1:0] nb, logic signed [DIST_W-1:0] fb,
                            logic [COLOR_W-1:0] src, logic [CHAN_W-1:0] wt,
                            logic [COLOR_W-1:0] dst, logic [CHAN_W-1:0] alpha,
                            logic [COORD-1:0] x, logic [COORD-1:0] y);
        blend_word_t w;
        w.action       = ACT_BLEND;
        w.table_word   = '0;
        w.near_a       = na;
        w.far_a        = fa;
        w.near_b       = nb;
        w.far_b        = fb;
        w.source_color = src;
        w.weight       = wt;
        w.dest_pixel   = dst;
        w.dest_alpha   = alpha;
        w.pixel_x      = x;
        w.pixel_y      = y;
        send_word(w);
    endtask

    function automatic logic signed [DIST_W-1:0] pick_dist();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return DIST_W'(live_idx[$urandom_range(0, LIVE_N - 1)]);
        if (r == 6)
            return $urandom_range(0, 1) ? 8'sh80 : 8'sh7F;
        if (r == 7)
            return $urandom_range(0, 1) ? DIST_W'(SIDE) : 8'shFF;
        if (r == 8)
            return DIST_W'($urandom_range(SIDE, 127));
        return DIST_W'(-int'($urandom_range(1, 128)));
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic blend_word_t random_word();
        blend_word_t w;
        w.action       = ($urandom_range(0, 4) == 0) ? ACT_LOAD : ACT_BLEND;
        w.table_word   = WORD_W'($urandom);
        w.near_a       = pick_dist();
        w.far_a        = pick_dist();
        w.near_b       = pick_dist();
        w.far_b        = pick_dist();
        w.source_color = pick_color();
        w.dest_pixel   = pick_color();
        case ($urandom_range(0, 9))
            0: w.weight = '0;
            1: w.weight = CHAN_MAX;
            2: w.weight = CHAN_W'($urandom_range(252, 254));
            default: w.weight = CHAN_W'($urandom);
        endcase
        w.dest_alpha = CHAN_W'($urandom);
        w.pixel_x    = COORD'($urandom);
        w.pixel_y    = COORD'($urandom);
        return w;
    endfunction

    task automatic run_random(int count);
        int sent;
        int burst;
        int i;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
            for (i = 0; i < burst && sent < count; i++)
            begin
                send_word(random_word());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending() != 0)
        begin
            $display("%0t: pixels never delivered, expected 0 pending, actual %0d",
                     $time, sb.pending());
            sb.errors += sb.pending();
            sb.pending_pixels.delete();
        end
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic alpha_on, logic [THR_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALPHA_ENABLE;
        cfg_data  <= THR_W'(alpha_on);
        @(posedge clk);
        cfg_index <= REG_OPAQUE_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(REG_ALPHA_ENABLE, THR_W'(alpha_on));
        sb.set_reg(REG_OPAQUE_THRESHOLD, thr);
    endtask

    task automatic run_phase(logic alpha_on, logic [THR_W-1:0] thr, int count);
        set_config(alpha_on, thr);
        run_random(count);
        wait_idle();
    endtask

    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every row and column that a clamped index of a blend word can select
        for (i = 0; i < LIVE_N * LIVE_N; i++)
            load_entry(live_idx[i / LIVE_N], live_idx[i % LIVE_N], CHAN_W'($urandom));

        load_entry(0, 0, 8'hFF);
        load_entry(SIDE - 1, 0, 8'h00);
        load_entry(0, SIDE - 1, 8'h00);
        load_entry(SIDE - 1, SIDE - 1, 8'h00);
        blend_at(0, 31, 0, 31, 24'hFFFFFF, 8'd255, 24'h000000, 8'h00, 0, 0);
        blend_at(0, 31, 0, 31, 24'hFFFFFF, 8'd253, 24'h000000, 8'h00, 1, 0);
        blend_at(0, 31, 0, 31, 24'hA5C35A, 8'd254, 24'h3C00FF, 8'h7F, 0, 1);
        blend_at(0, 31, 0, 31, 24'hFFFFFF, 8'd0, 24'h123456, 8'hFF, 2047, 0);
        blend_at(-128, 127, -1, 32, 24'h000000, 8'd255, 24'hFFFFFF, 8'hFF, 2047, 2047);
        blend_at(5, 5, 7, 9, 24'hFFFFFF, 8'd255, 24'h000000, 8'h01, 0, 2047);
        // invert the corners for the most negative filter
        load_entry(0, 0, 8'h00);
        load_entry(SIDE - 1, 0, 8'hFF);
        load_entry(0, SIDE - 1, 8'hFF);
        load_entry(SIDE - 1, SIDE - 1, 8'h00);
        blend_at(0, 31, 0, 31, 24'hFF00FF, 8'd255, 24'h00FF00, 8'h80, 1024, 1);
        blend_at(0, 31, 0, 31, 24'h80FF01, 8'd1, 24'h7F00FE, 8'hC3, 3, 1365);
        send_word('{action: ACT_LOAD, table_word: '1, default: '0});
        blend_at(0, 31, 0, 31, 24'hFFFFFF, 8'd200, 24'h5A5A5A, 8'h00, 682, 5);
        send_word('{action: ACT_LOAD, table_word: '0, default: '0});
        blend_at(-1, -1, -1, -1, 24'hFFFFFF, 8'd255, 24'h000000, 8'hFE, 7, 7);
        wait_idle();

        run_phase(1'b1, '0, 55);
        run_phase(1'b0, THR_MAX, 55);
        run_phase(1'b1, THR_MAX, 50);
        run_phase(1'b0, THR_W'($urandom_range(0, 20000)), 55);
        run_phase(1'b1, OPAQUE_RESET, 55);
        run_phase(1'b1, THR_W'($urandom_range(0, 131071)), 50);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
